FILE: src/pwfs_pkg.sv
// Package for the protobuf wire field scanner: queue entry type, status and
// wire type codes, and sizing constants. No dependencies.
package pwfs_pkg;

   typedef logic [1:0] status_type;
   typedef logic [2:0] wire_kind_type;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_TOO_LONG  = 2'd1;
   localparam status_type ST_TRUNCATED = 2'd2;
   localparam status_type ST_BAD_TYPE  = 2'd3;

   localparam wire_kind_type WT_VARINT      = 3'd0;
   localparam wire_kind_type WT_FIXED64     = 3'd1;
   localparam wire_kind_type WT_LENGTH      = 3'd2;
   localparam wire_kind_type WT_GROUP_START = 3'd3;
   localparam wire_kind_type WT_GROUP_END   = 3'd4;
   localparam wire_kind_type WT_FIXED32     = 3'd5;

   localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;
   localparam logic [63:0] FIXED64_BYTES = 64'd8;
   localparam logic [63:0] FIXED32_BYTES = 64'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [6:0] payload_bits;
      logic       cont;
      logic       last;
   } entry_type;

endpackage

FILE: src/pwfs_if.sv
// Valid/ready channel interfaces for the byte input and the field result.
// Depends on pwfs_pkg.
interface pwfs_req_if;
   import pwfs_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_in_buffer;
   modport source (output valid, output in_byte, output last_in_buffer, input ready);
   modport sink (input valid, input in_byte, input last_in_buffer, output ready);
endinterface

interface pwfs_rsp_if;
   import pwfs_pkg::*;
   logic          valid;
   logic          ready;
   logic [31:0]   field_number;
   wire_kind_type wire_kind;
   logic [63:0]   field_value;
   status_type    status;
   modport source (output valid, output field_number, output wire_kind,
                   output field_value, output status, input ready);
   modport sink (input valid, input field_number, input wire_kind,
                 input field_value, input status, output ready);
endinterface

FILE: src/pwfs_front.sv
// Front stage: accepts input bytes and splits each into its seven data bits,
// continuation flag and end-of-buffer flag. Depends on pwfs_pkg, pwfs_if.
module pwfs_front (
   input  logic             clock,
   input  logic             reset,
   pwfs_req_if.sink         req_if,
   output logic             entry_valid,
   output pwfs_pkg::entry_type entry,
   input  logic             entry_ready
);
   import pwfs_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   logic      take;

   assign req_if.ready = !valid_ff || entry_ready;
   assign take = req_if.valid && req_if.ready;
   assign valid_in = take || (valid_ff && !entry_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         entry_ff.payload_bits <= req_if.in_byte[6:0];
         entry_ff.cont <= req_if.in_byte[7];
         entry_ff.last <= req_if.last_in_buffer;
      end
   end

   assign entry_valid = valid_ff;
   assign entry = entry_ff;

endmodule

FILE: src/pwfs_queue.sv
// Short flip-flop queue between the front stage and the field parser.
// Depends on pwfs_pkg.
module pwfs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  pwfs_pkg::entry_type push_entry,
   output logic                push_ready,
   output logic                pop_valid,
   output pwfs_pkg::entry_type pop_entry,
   input  logic                pop_ready
);
   import pwfs_pkg::*;

   entry_type             store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = store_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/pwfs_back.sv
// Field parser: decodes keys, varints, lengths and skips payload bytes, and
// holds one result in an output register. Depends on pwfs_pkg, pwfs_if.
module pwfs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                entry_valid,
   input  pwfs_pkg::entry_type entry,
   output logic                entry_ready,
   pwfs_rsp_if.source          rsp_if
);
   import pwfs_pkg::*;

   typedef enum logic [2:0] {
      PH_KEY, PH_VALUE, PH_LENGTH, PH_PAYLOAD, PH_DRAIN
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [63:0]   acc_ff, acc_in;
   logic [3:0]    idx_ff, idx_in;
   logic [31:0]   held_num_ff, held_num_in;
   wire_kind_type held_type_ff, held_type_in;
   logic [63:0]   held_len_ff, held_len_in;
   logic [63:0]   remain_ff, remain_in;

   logic          rsp_valid_ff;
   logic [31:0]   rsp_num_ff;
   wire_kind_type rsp_type_ff;
   logic [63:0]   rsp_value_ff;
   status_type    rsp_status_ff;

   logic          step;
   logic          emit;
   logic          keyed;
   logic [63:0]   emit_value;
   status_type    emit_status;
   logic [6:0]    shamt;
   logic [63:0]   acc_new;
   logic [63:0]   rem_dec;

   assign step = entry_valid && (!rsp_valid_ff || rsp_if.ready);
   assign entry_ready = step;
   assign shamt = {idx_ff, 3'b000} - {3'b000, idx_ff};
   assign acc_new = acc_ff | (64'(entry.payload_bits) << shamt);
   assign rem_dec = remain_ff - 64'd1;

   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff;
      idx_in = idx_ff;
      held_num_in = held_num_ff;
      held_type_in = held_type_ff;
      held_len_in = held_len_ff;
      remain_in = remain_ff;
      emit = 1'b0;
      keyed = 1'b1;
      emit_value = '0;
      emit_status = ST_OK;
      case (phase_ff)
         PH_DRAIN: begin
            if (entry.last) begin
               phase_in = PH_KEY;
            end
         end
         PH_PAYLOAD: begin
            remain_in = rem_dec;
            if (rem_dec == '0) begin
               emit = 1'b1;
               emit_value = (held_type_ff == WT_LENGTH) ? held_len_ff : '0;
               phase_in = PH_KEY;
            end else if (entry.last) begin
               emit = 1'b1;
               emit_status = ST_TRUNCATED;
               remain_in = '0;
               phase_in = PH_KEY;
            end
         end
         default: begin
            keyed = phase_ff != PH_KEY;
            if (idx_ff >= MAX_VARINT_BYTES) begin
               emit = 1'b1;
               emit_status = ST_TOO_LONG;
               acc_in = '0;
               idx_in = '0;
               remain_in = '0;
               phase_in = entry.last ? PH_KEY : PH_DRAIN;
            end else if (entry.cont) begin
               if (entry.last) begin
                  emit = 1'b1;
                  emit_status = ST_TRUNCATED;
                  acc_in = '0;
                  idx_in = '0;
                  remain_in = '0;
                  phase_in = PH_KEY;
               end else begin
                  acc_in = acc_new;
                  idx_in = idx_ff + 4'd1;
               end
            end else begin
               acc_in = '0;
               idx_in = '0;
               if (phase_ff == PH_KEY) begin
                  keyed = 1'b1;
                  held_num_in = acc_new[34:3];
                  held_type_in = acc_new[2:0];
                  held_len_in = '0;
                  case (acc_new[2:0])
                     WT_VARINT: phase_in = PH_VALUE;
                     WT_LENGTH: phase_in = PH_LENGTH;
                     WT_FIXED64: begin
                        remain_in = FIXED64_BYTES;
                        phase_in = PH_PAYLOAD;
                     end
                     WT_FIXED32: begin
                        remain_in = FIXED32_BYTES;
                        phase_in = PH_PAYLOAD;
                     end
                     WT_GROUP_START, WT_GROUP_END: begin
                        emit = 1'b1;
                        phase_in = PH_KEY;
                     end
                     default: begin
                        emit = 1'b1;
                        emit_status = ST_BAD_TYPE;
                        remain_in = '0;
                        phase_in = entry.last ? PH_KEY : PH_DRAIN;
                     end
                  endcase
                  if (!emit && entry.last) begin
                     emit = 1'b1;
                     emit_status = ST_TRUNCATED;
                     remain_in = '0;
                     phase_in = PH_KEY;
                  end
               end else if (phase_ff == PH_VALUE) begin
                  emit = 1'b1;
                  emit_value = acc_new;
                  phase_in = PH_KEY;
               end else begin
                  held_len_in = acc_new;
                  if (acc_new == '0) begin
                     emit = 1'b1;
                     phase_in = PH_KEY;
                  end else if (entry.last) begin
                     emit = 1'b1;
                     emit_status = ST_TRUNCATED;
                     remain_in = '0;
                     phase_in = PH_KEY;
                  end else begin
                     remain_in = acc_new;
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEY;
         acc_ff <= '0;
         idx_ff <= '0;
         held_num_ff <= '0;
         held_type_ff <= '0;
         held_len_ff <= '0;
         remain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            acc_ff <= acc_in;
            idx_ff <= idx_in;
            held_num_ff <= held_num_in;
            held_type_ff <= held_type_in;
            held_len_ff <= held_len_in;
            remain_ff <= remain_in;
         end
         if (step && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step && emit) begin
         rsp_num_ff <= keyed ? held_num_in : '0;
         rsp_type_ff <= keyed ? held_type_in : '0;
         rsp_value_ff <= emit_value;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.field_number = rsp_num_ff;
   assign rsp_if.wire_kind = rsp_type_ff;
   assign rsp_if.field_value = rsp_value_ff;
   assign rsp_if.status = rsp_status_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= MAX_VARINT_BYTES)
      else $error("Varint byte index ran past the limit.");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remain_ff != '0)
      else $error("Payload phase entered with nothing left to skip.");

   a_error_drains: assert property (@(posedge clock) disable iff (reset)
      step && emit && emit_status != ST_OK && emit_status != ST_TRUNCATED && !entry.last
      |=> phase_ff == PH_DRAIN)
      else $error("An error before the end of the buffer did not start draining.");

   a_stall_waits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !step)
      else $error("Parser advanced while a result was still waiting.");

endmodule

FILE: src/protobuf_wire_field_scanner_top.sv
// Top level of the protobuf wire-format field scanner.
// Depends on pwfs_pkg, pwfs_if, pwfs_front, pwfs_queue and pwfs_back.
//
// Bytes of an encoded buffer enter on req_if, one per word, with
// last_in_buffer set on the final byte. Each completed field, and each
// parse error, leaves on rsp_if as one word carrying the field number,
// wire type, varint value or length, and a status code. Bytes that do not
// finish a field give no word.
// A byte passes an input register, a four-entry queue and the parser; its
// result is then held in the parser's output register.
// The scanner takes one byte per cycle; the parser handles one byte per
// cycle, so throughput is one byte per cycle while rsp_if.ready is high.
// When the receiver stalls, the result register holds its word, the parser
// waits, and the queue and input register absorb up to five more bytes before req_if.ready
// drops. Reset clears all parse state; the scanner then awaits a key.
// After an error, the rest of that buffer is skipped without results.
module protobuf_wire_field_scanner_top (
   input  logic        clock,
   input  logic        reset,
   pwfs_req_if.sink    req_if,
   pwfs_rsp_if.source  rsp_if
);
   import pwfs_pkg::*;

   logic      front_valid;
   entry_type front_entry;
   logic      front_ready;
   logic      queue_valid;
   entry_type queue_entry;
   logic      queue_ready;

   pwfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .entry_valid (front_valid),
      .entry       (front_entry),
      .entry_ready (front_ready)
   );

   pwfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_entry (front_entry),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_entry  (queue_entry),
      .pop_ready  (queue_ready)
   );

   pwfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_valid),
      .entry       (queue_entry),
      .entry_ready (queue_ready),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for protobuf_wire_field_scanner_top: it sends encoded buffers
// one byte per word and checks every field word against a built-in decoder.
// Depends on pwfs_pkg, pwfs_if and the scanner RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pwfs_pkg::*;

   typedef enum logic [2:0] {
      SCAN_KEY,
      SCAN_VALUE,
      SCAN_LENGTH,
      SCAN_PAYLOAD,
      SCAN_SKIP
   } scan_phase_type;

   typedef struct {
      logic [31:0]   number;
      wire_kind_type wtype;
      logic [63:0]   value;
      status_type    status;
   } field_word_type;

   logic clock;
   logic reset;

   pwfs_req_if req_if ();
   pwfs_rsp_if rsp_if ();

   protobuf_wire_field_scanner_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   field_word_type expected_fields[$];
   logic [7:0]     buffer_q[$];

   scan_phase_type scan_phase;
   logic [63:0]    varint_acc;
   logic [3:0]     varint_count;
   logic [31:0]    cur_number;
   wire_kind_type  cur_wire_kind;
   logic [63:0]    cur_length;
   logic [63:0]    bytes_left;

   int error_count;
   int bytes_parsed;
   int buffers_sent;
   int words_checked;
   int error_words;
   bit sender_gaps_on;
   bit receiver_stalls_on;
   bit long_hold_request;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void expect_word(logic keyed, logic [63:0] value, status_type status);
      field_word_type w;
      w.number = keyed ? cur_number : 32'd0;
      w.wtype  = keyed ? cur_wire_kind : WT_VARINT;
      w.value  = value;
      w.status = status;
      expected_fields.push_back(w);
   endfunction

   function automatic void scan_error(logic keyed, status_type status, logic last);
      expect_word(keyed, 64'd0, status);
      varint_acc   = 64'd0;
      varint_count = 4'd0;
      bytes_left   = 64'd0;
      scan_phase   = last ? SCAN_KEY : SCAN_SKIP;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic last);
      logic        keyed;
      logic [63:0] v;
      keyed = (scan_phase != SCAN_KEY);
      if (scan_phase == SCAN_SKIP) begin
         if (last) begin
            scan_phase = SCAN_KEY;
         end
         return;
      end
      bytes_parsed++;
      if (scan_phase == SCAN_PAYLOAD) begin
         bytes_left = bytes_left - 64'd1;
         if (bytes_left == 64'd0) begin
            expect_word(1'b1, (cur_wire_kind == WT_LENGTH) ? cur_length : 64'd0, ST_OK);
            scan_phase = SCAN_KEY;
         end else if (last) begin
            scan_error(1'b1, ST_TRUNCATED, 1'b1);
         end
         return;
      end
      if (varint_count >= MAX_VARINT_BYTES) begin
         scan_error(keyed, ST_TOO_LONG, last);
         return;
      end
      varint_acc = varint_acc | ({57'd0, b[6:0]} << (7 * varint_count));
      varint_count++;
      if (b[7]) begin
         if (last) begin
            scan_error(keyed, ST_TRUNCATED, 1'b1);
         end
         return;
      end
      v = varint_acc;
      varint_acc = 64'd0;
      varint_count = 4'd0;
      case (scan_phase)
         SCAN_KEY: begin
            cur_number    = v[34:3];
            cur_wire_kind = v[2:0];
            cur_length    = 64'd0;
            case (cur_wire_kind)
               WT_VARINT: scan_phase = SCAN_VALUE;
               WT_LENGTH: scan_phase = SCAN_LENGTH;
               WT_FIXED64: begin
                  bytes_left = FIXED64_BYTES;
                  scan_phase = SCAN_PAYLOAD;
               end
               WT_FIXED32: begin
                  bytes_left = FIXED32_BYTES;
                  scan_phase = SCAN_PAYLOAD;
               end
               WT_GROUP_START, WT_GROUP_END: begin
                  expect_word(1'b1, 64'd0, ST_OK);
                  scan_phase = SCAN_KEY;
                  return;
               end
               default: begin
                  scan_error(1'b1, ST_BAD_TYPE, last);
                  return;
               end
            endcase
            if (last) begin
               scan_error(1'b1, ST_TRUNCATED, 1'b1);
            end
         end
         SCAN_VALUE: begin
            expect_word(1'b1, v, ST_OK);
            scan_phase = SCAN_KEY;
         end
         default: begin
            cur_length = v;
            if (v == 64'd0) begin
               expect_word(1'b1, 64'd0, ST_OK);
               scan_phase = SCAN_KEY;
            end else begin
               bytes_left = v;
               scan_phase = SCAN_PAYLOAD;
               if (last) begin
                  scan_error(1'b1, ST_TRUNCATED, 1'b1);
               end
            end
         end
      endcase
   endfunction

   function automatic void check_value(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      field_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         words_checked++;
         if (rsp_if.status != ST_OK) begin
            error_words++;
         end
         if (expected_fields.size() == 0) begin
            $display({"%0t: unexpected word, expected none, ",
                      "actual number %0h type %0d value %0h status %0d"},
                     $time, rsp_if.field_number, rsp_if.wire_kind, rsp_if.field_value,
                     rsp_if.status);
            error_count++;
         end else begin
            want = expected_fields.pop_front();
            check_value("field_number", want.number, rsp_if.field_number);
            check_value("wire_kind", want.wtype, rsp_if.wire_kind);
            check_value("field_value", want.value, rsp_if.field_value);
            check_value("status", want.status, rsp_if.status);
         end
      end
   end

   initial begin : rsp_ready_driver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            hold_left = 40;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : run_limit
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Entered and left at a falling edge; valid stays high between back-to-back bytes.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.last_in_buffer <= last;
      do @(posedge clock); while (!req_if.ready);
      decode_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_buffer();
      int i;
      for (i = 0; i < buffer_q.size(); i++) begin
         send_byte(buffer_q[i], i == buffer_q.size() - 1);
      end
      buffer_q.delete();
      buffers_sent++;
   endtask

   function automatic void put_varint(logic [63:0] v, int pad_to);
      logic [6:0] chunk;
      logic       more;
      int         n;
      n = 0;
      do begin
         chunk = v[6:0];
         v = v >> 7;
         n++;
         more = (v != 64'd0) || (n < pad_to);
         buffer_q.push_back({more, chunk});
      end while (more);
   endfunction

   function automatic int pad_length();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 1;
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 127);
         1: return $urandom_range(0, 65535);
         2: return {$urandom, $urandom};
         default: begin
            case ($urandom_range(0, 2))
               0: return 64'd0;
               1: return '1;
               default: return 64'h8000_0000_0000_0000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [63:0] random_key(wire_kind_type wt);
      logic [63:0] key;
      case ($urandom_range(0, 3))
         0, 1: key = {$urandom_range(0, 31), wt};
         2: key = {$urandom, wt};
         default: begin
            key = {$urandom, $urandom};
            key[2:0] = wt;
         end
      endcase
      return key;
   endfunction

   function automatic void put_random_field();
      wire_kind_type wt;
      int            len;
      case ($urandom_range(0, 9))
         0, 1, 2, 9: wt = WT_VARINT;
         3: wt = WT_FIXED64;
         4: wt = WT_FIXED32;
         5, 6: wt = WT_LENGTH;
         7: wt = WT_GROUP_START;
         default: wt = WT_GROUP_END;
      endcase
      put_varint(random_key(wt), pad_length());
      case (wt)
         WT_VARINT: begin
            if ($urandom_range(0, 7) == 0) begin
               // Ten bytes whose top bits fall beyond 64 and are dropped.
               repeat (9) buffer_q.push_back(8'h80 | 8'($urandom));
               buffer_q.push_back(8'($urandom_range(0, 127)));
            end else begin
               put_varint(pick_value(), pad_length());
            end
         end
         WT_FIXED64: repeat (8) buffer_q.push_back(8'($urandom));
         WT_FIXED32: repeat (4) buffer_q.push_back(8'($urandom));
         WT_LENGTH: begin
            len = $urandom_range(0, 6);
            put_varint(len, pad_length());
            repeat (len) buffer_q.push_back(8'($urandom));
         end
         default: ;
      endcase
   endfunction

   function automatic void put_broken_tail();
      logic [63:0] key;
      case ($urandom_range(0, 3))
         0: begin
            put_random_field();
            repeat ($urandom_range(1, 3)) begin
               if (buffer_q.size() > 1) begin
                  void'(buffer_q.pop_back());
               end
            end
         end
         1: begin
            key = {$urandom_range(0, 200), 3'b110};
            key[0] = $urandom_range(0, 1);
            put_varint(key, pad_length());
            repeat ($urandom_range(0, 3)) buffer_q.push_back(8'($urandom));
         end
         2: begin
            put_varint(random_key($urandom_range(0, 1) ? WT_VARINT : WT_LENGTH), 1);
            repeat ($urandom_range(10, 12)) buffer_q.push_back(8'h80 | 8'($urandom));
            repeat ($urandom_range(0, 2)) buffer_q.push_back(8'($urandom));
         end
         default: begin
            put_varint(random_key(WT_LENGTH), 1);
            put_varint(pick_value() | 64'h100, 1);
            repeat ($urandom_range(0, 3)) buffer_q.push_back(8'($urandom));
         end
      endcase
   endfunction

   task automatic test_field_types();
      // Every wire type, a zero-length field, and a buffer ending on a field boundary.
      buffer_q = '{8'h08, 8'h00, 8'h1B, 8'h1C, 8'h0D, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
                   8'h12, 8'h00, 8'h12, 8'h01, 8'h7F, 8'h09, 8'h00, 8'h11, 8'h22,
                   8'h33, 8'h44, 8'h55, 8'h66, 8'hFF};
      send_buffer();
      put_varint({32'hFFFF_FFFF, WT_VARINT}, 1);
      put_varint('1, 1);
      send_buffer();
   endtask

   task automatic test_error_cases();
      buffer_q = '{8'h0E};
      send_buffer();
      buffer_q = '{8'h80};
      send_buffer();
      buffer_q = '{8'h08};
      send_buffer();
      buffer_q = '{8'h0F, 8'h00, 8'h55};
      send_buffer();
      buffer_q = '{8'h0D, 8'h01, 8'h02};
      send_buffer();
      buffer_q = '{8'h08};
      repeat (10) buffer_q.push_back(8'hFF);
      buffer_q.push_back(8'h00);
      send_buffer();
   endtask

   task automatic test_backpressure();
      int i;
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
      long_hold_request = 1'b1;
      for (i = 0; i < 16; i++) begin
         buffer_q.push_back({1'b0, i[3:0], (i % 2 == 1) ? WT_GROUP_END : WT_GROUP_START});
      end
      send_buffer();
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
   endtask

   task automatic test_random_buffers();
      int start;
      int kind;
      start = bytes_parsed;
      while (bytes_parsed - start < 1000) begin
         if (bytes_parsed - start > 850) begin
            sender_gaps_on = 1'b0;
            receiver_stalls_on = 1'b0;
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 8)) buffer_q.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) put_random_field();
            if (kind >= 8) begin
               put_broken_tail();
            end
         end
         send_buffer();
      end
   endtask

   initial begin : main_sequence
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.in_byte = 8'd0;
      req_if.last_in_buffer = 1'b0;
      scan_phase = SCAN_KEY;
      varint_acc = 64'd0;
      varint_count = 4'd0;
      cur_number = 32'd0;
      cur_wire_kind = WT_VARINT;
      cur_length = 64'd0;
      bytes_left = 64'd0;
      error_count = 0;
      bytes_parsed = 0;
      buffers_sent = 0;
      words_checked = 0;
      error_words = 0;
      long_hold_request = 1'b0;
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_types();
      test_error_cases();
      test_backpressure();
      test_random_buffers();

      req_if.valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Parsed %0d bytes in %0d buffers; checked %0d field words, %0d of them errors.",
               bytes_parsed, buffers_sent, words_checked, error_words);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
